// ----- rtl/hashed_transition_table_fsm_macros.svh -----
// assertion macros for the hashed transition table state machine
// used by modules that check their own control logic; expects clk and rst_n in scope
`ifndef HASHED_TRANSITION_TABLE_FSM_MACROS_SVH
`define HASHED_TRANSITION_TABLE_FSM_MACROS_SVH

// same-cycle implication, disabled during reset
`define HTT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define HTT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/htt_pkg.sv -----
// shared types and constants for the hashed transition table state machine
// no dependencies; used by the top, the sequencer and the test files
`timescale 1ns / 1ps

package htt_pkg;

  localparam int HID_W      = 8;
  localparam int STATE_PT_W = 8;
  localparam int EVENT_PT_W = 8;
  localparam int ARG_W      = 32;
  localparam int SLOT_W     = 8;
  localparam int STS_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int TSIZE_W    = 9;

  localparam logic CMD_DEFINE = 1'b0;
  localparam logic CMD_EVENT  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_STATE = 2'd1;

  typedef enum logic [STS_W-1:0] {
    STS_DEFINED  = 2'd0,
    STS_FULL     = 2'd1,
    STS_TAKEN    = 2'd2,
    STS_NO_TRANS = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CLEAR = 5'b00010,
    ST_HASH  = 5'b00100,
    ST_PROBE = 5'b01000,
    ST_DONE  = 5'b10000
  } seq_state_t;

  // configuration side effects handed to the sequencer
  typedef struct packed {
    logic clear;
    logic load_state;
  } cfg_evt_t;

endpackage

// ----- rtl/hashed_transition_table_fsm.sv -----
// Hashed transition table state machine. Requests enter on the in_ channel: cmd 0
// stores a transition (from_state, event_id) -> (to_state, handler_id) in the first free
// slot probed linearly from (from_state + event_id * 2^STATE_BITS) mod table size; cmd 1
// delivers event_id in the present state, probing the same way for a matching slot.
// Every request gives exactly one result on the out_ channel: status, slot, handler,
// handler argument (event payload on a hit, event id on a miss, else 0), final state.
// Steps: accept, hash in the bit-serial remainder unit, probe slot by slot through the
// slot memory read port, register the result; a full miss probes all table-size slots.
// One request is in work at a time; in_ready is high only while the sequencer is idle.
// Results sit in an output register; a stalled receiver holds the result and a finished
// request waits for it, while the next request can already be accepted and hashed.
// Configuration (cfg_ channel, always ready): index 0 sets the table size (0 acts as 1,
// above TABLE_DEPTH acts as TABLE_DEPTH) and empties the table; index 1 sets the
// initial state and loads it as the present state. Write only while idle.
// After reset and after each table size write, a clearing pass empties all TABLE_DEPTH
// slots, one slot per cycle, with in_ready low. Reset: size 256 (or TABLE_DEPTH if
// smaller), initial and present state 0.
// depends on htt_pkg, htt_mod_unit, htt_slot_mem and htt_seq
`timescale 1ns / 1ps

module hashed_transition_table_fsm #(
  parameter int TABLE_DEPTH = 256,
  parameter int STATE_BITS  = 8,
  parameter int EVENT_BITS  = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_cmd,
  input  logic [htt_pkg::STATE_PT_W-1:0]  in_from_state,
  input  logic [htt_pkg::STATE_PT_W-1:0]  in_to_state,
  input  logic [htt_pkg::EVENT_PT_W-1:0]  in_event_id,
  input  logic [htt_pkg::HID_W-1:0]       in_handler_id,
  input  logic [htt_pkg::ARG_W-1:0]       in_payload,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [htt_pkg::STS_W-1:0]       out_status,
  output logic [htt_pkg::SLOT_W-1:0]      out_slot,
  output logic [htt_pkg::HID_W-1:0]       out_handler_to_call,
  output logic [htt_pkg::ARG_W-1:0]       out_handler_arg,
  output logic [htt_pkg::STATE_PT_W-1:0]  out_current_state,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [htt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [htt_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int ADDR_W  = $clog2(TABLE_DEPTH);
  localparam int SIZE_W  = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W   = STATE_BITS + EVENT_BITS;
  localparam int ENTRY_W = 1 + 2 * STATE_BITS + EVENT_BITS + htt_pkg::HID_W;
  localparam int RST_SIZE = (TABLE_DEPTH < 256) ? TABLE_DEPTH : 256;

  logic [SIZE_W-1:0]            eff_size_r, eff_size_nxt;
  logic [htt_pkg::TSIZE_W-1:0]  tsize_in;
  logic                         cfg_fire;
  htt_pkg::cfg_evt_t            cfg_evt;

  logic                         mod_start;
  logic [KEY_W-1:0]             mod_key;
  logic                         mod_done;
  logic [ADDR_W-1:0]            mod_rem;
  logic                         mem_we;
  logic [ADDR_W-1:0]            mem_waddr;
  logic [ENTRY_W-1:0]           mem_wdata;
  logic                         mem_re;
  logic [ADDR_W-1:0]            mem_raddr;
  logic [ENTRY_W-1:0]           mem_rdata;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign tsize_in  = cfg_wdata[htt_pkg::TSIZE_W-1:0];

  assign cfg_evt.clear      = cfg_fire && (cfg_index == htt_pkg::CFG_TABLE_SIZE);
  assign cfg_evt.load_state = cfg_fire && (cfg_index == htt_pkg::CFG_INITIAL_STATE);

  // clamp the written size into 1..TABLE_DEPTH once, at write time
  always_comb begin
    eff_size_nxt = eff_size_r;
    if (cfg_evt.clear) begin
      if (tsize_in == '0) begin
        eff_size_nxt = SIZE_W'(1);
      end else if (32'(tsize_in) > 32'(TABLE_DEPTH)) begin
        eff_size_nxt = SIZE_W'(TABLE_DEPTH);
      end else begin
        eff_size_nxt = SIZE_W'(tsize_in);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_size_r <= SIZE_W'(RST_SIZE);
    end else begin
      eff_size_r <= eff_size_nxt;
    end
  end

  htt_mod_unit #(
    .KEY_W  (KEY_W),
    .SIZE_W (SIZE_W),
    .ADDR_W (ADDR_W)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (mod_key),
    .divisor   (eff_size_r),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  htt_slot_mem #(
    .DATA_W (ENTRY_W),
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  htt_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .STATE_BITS  (STATE_BITS),
    .EVENT_BITS  (EVENT_BITS),
    .ADDR_W      (ADDR_W),
    .SIZE_W      (SIZE_W),
    .KEY_W       (KEY_W),
    .ENTRY_W     (ENTRY_W)
  ) u_seq (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cmd              (in_cmd),
    .in_from_state       (in_from_state),
    .in_to_state         (in_to_state),
    .in_event_id         (in_event_id),
    .in_handler_id       (in_handler_id),
    .in_payload          (in_payload),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_slot            (out_slot),
    .out_handler_to_call (out_handler_to_call),
    .out_handler_arg     (out_handler_arg),
    .out_current_state   (out_current_state),
    .cfg_evt             (cfg_evt),
    .init_state          (cfg_wdata[htt_pkg::STATE_PT_W-1:0]),
    .eff_size            (eff_size_r),
    .mod_start           (mod_start),
    .mod_key             (mod_key),
    .mod_done            (mod_done),
    .mod_rem             (mod_rem),
    .mem_we              (mem_we),
    .mem_waddr           (mem_waddr),
    .mem_wdata           (mem_wdata),
    .mem_re              (mem_re),
    .mem_raddr           (mem_raddr),
    .mem_rdata           (mem_rdata)
  );

endmodule

// ----- rtl/htt_mod_unit.sv -----
// iterative remainder unit: key mod size, one dividend bit per cycle
// depends on nothing but its parameters
`timescale 1ns / 1ps

module htt_mod_unit #(
  parameter int KEY_W  = 16,
  parameter int SIZE_W = 9,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [KEY_W-1:0]  dividend,
  input  logic [SIZE_W-1:0] divisor,
  output logic              done,
  output logic [ADDR_W-1:0] remainder
);

  localparam int CNT_W = $clog2(KEY_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [KEY_W-1:0]  shreg_r, shreg_nxt;
  logic [SIZE_W-1:0] rem_r, rem_nxt;
  logic [SIZE_W:0]   trial;
  logic [SIZE_W:0]   diff;

  assign trial = {rem_r, shreg_r[KEY_W-1]};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    shreg_nxt = shreg_r;
    rem_nxt   = rem_r;
    if (start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      shreg_nxt = dividend;
      rem_nxt   = '0;
    end else if (busy_r) begin
      // restoring step: partial remainder stays below the divisor
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = diff[SIZE_W-1:0];
      end else begin
        rem_nxt = trial[SIZE_W-1:0];
      end
      shreg_nxt = shreg_r << 1;
      cnt_nxt   = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(KEY_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    shreg_r <= shreg_nxt;
    rem_r   <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = ADDR_W'(rem_r);

endmodule

// ----- rtl/htt_slot_mem.sv -----
// transition slot storage: one write port, one registered read port
// depends on nothing but its parameters
`timescale 1ns / 1ps

module htt_slot_mem #(
  parameter int DATA_W = 41,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/htt_seq.sv -----
// sequencer: clear, capture, hash wait, linear probe, slot write, result register
// depends on htt_pkg and hashed_transition_table_fsm_macros.svh
`timescale 1ns / 1ps
`include "hashed_transition_table_fsm_macros.svh"

module htt_seq #(
  parameter int TABLE_DEPTH = 256,
  parameter int STATE_BITS  = 8,
  parameter int EVENT_BITS  = 8,
  parameter int ADDR_W      = 8,
  parameter int SIZE_W      = 9,
  parameter int KEY_W       = 16,
  parameter int ENTRY_W     = 41
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_cmd,
  input  logic [htt_pkg::STATE_PT_W-1:0] in_from_state,
  input  logic [htt_pkg::STATE_PT_W-1:0] in_to_state,
  input  logic [htt_pkg::EVENT_PT_W-1:0] in_event_id,
  input  logic [htt_pkg::HID_W-1:0]      in_handler_id,
  input  logic [htt_pkg::ARG_W-1:0]      in_payload,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [htt_pkg::STS_W-1:0]      out_status,
  output logic [htt_pkg::SLOT_W-1:0]     out_slot,
  output logic [htt_pkg::HID_W-1:0]      out_handler_to_call,
  output logic [htt_pkg::ARG_W-1:0]      out_handler_arg,
  output logic [htt_pkg::STATE_PT_W-1:0] out_current_state,
  input  htt_pkg::cfg_evt_t              cfg_evt,
  input  logic [htt_pkg::STATE_PT_W-1:0] init_state,
  input  logic [SIZE_W-1:0]              eff_size,
  output logic                           mod_start,
  output logic [KEY_W-1:0]               mod_key,
  input  logic                           mod_done,
  input  logic [ADDR_W-1:0]              mod_rem,
  output logic                           mem_we,
  output logic [ADDR_W-1:0]              mem_waddr,
  output logic [ENTRY_W-1:0]             mem_wdata,
  output logic                           mem_re,
  output logic [ADDR_W-1:0]              mem_raddr,
  input  logic [ENTRY_W-1:0]             mem_rdata
);

  typedef struct packed {
    logic                     valid;
    logic [STATE_BITS-1:0]    from_st;
    logic [STATE_BITS-1:0]    to_st;
    logic [EVENT_BITS-1:0]    ev;
    logic [htt_pkg::HID_W-1:0] hid;
  } entry_t;

  htt_pkg::seq_state_t st_r, st_nxt;

  logic                      cmd_r, cmd_nxt;
  logic [STATE_BITS-1:0]     from_r, from_nxt;
  logic [STATE_BITS-1:0]     to_r, to_nxt;
  logic [EVENT_BITS-1:0]     ev_r, ev_nxt;
  logic [htt_pkg::HID_W-1:0] hid_r, hid_nxt;
  logic [htt_pkg::ARG_W-1:0] pay_r, pay_nxt;
  logic [STATE_BITS-1:0]     present_r, present_nxt;
  logic [ADDR_W-1:0]         probe_idx_r, probe_idx_nxt;
  logic [SIZE_W-1:0]         issued_r, issued_nxt;
  logic                      pend_r, pend_nxt;
  logic [ADDR_W-1:0]         pend_addr_r, pend_addr_nxt;
  logic                      found_r, found_nxt;
  logic [ADDR_W-1:0]         slot_r, slot_nxt;
  logic [STATE_BITS-1:0]     hit_to_r, hit_to_nxt;
  logic [htt_pkg::HID_W-1:0] hit_hid_r, hit_hid_nxt;
  logic [ADDR_W-1:0]         clr_cnt_r, clr_cnt_nxt;

  logic                         out_valid_r, out_valid_nxt;
  htt_pkg::status_t             out_status_r, out_status_nxt;
  logic [htt_pkg::SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [htt_pkg::HID_W-1:0]    out_handler_r, out_handler_nxt;
  logic [htt_pkg::ARG_W-1:0]    out_arg_r, out_arg_nxt;
  logic [htt_pkg::STATE_PT_W-1:0] out_state_r, out_state_nxt;

  entry_t rd_ent;
  entry_t wr_ent;
  logic   match;
  logic   probe_wrap;

  assign rd_ent = mem_rdata;
  assign in_ready = (st_r == htt_pkg::ST_IDLE);

  // define looks for a free slot, event looks for its own (state, event) key
  always_comb begin
    if (cmd_r == htt_pkg::CMD_DEFINE) begin
      match = !rd_ent.valid;
    end else begin
      match = rd_ent.valid && (rd_ent.from_st == present_r) && (rd_ent.ev == ev_r);
    end
  end

  assign probe_wrap = (SIZE_W'(probe_idx_r) + SIZE_W'(1)) == eff_size;

  always_comb begin
    wr_ent.valid   = 1'b1;
    wr_ent.from_st = from_r;
    wr_ent.to_st   = to_r;
    wr_ent.ev      = ev_r;
    wr_ent.hid     = hid_r;
  end

  always_comb begin
    st_nxt          = st_r;
    cmd_nxt         = cmd_r;
    from_nxt        = from_r;
    to_nxt          = to_r;
    ev_nxt          = ev_r;
    hid_nxt         = hid_r;
    pay_nxt         = pay_r;
    present_nxt     = present_r;
    probe_idx_nxt   = probe_idx_r;
    issued_nxt      = issued_r;
    pend_nxt        = pend_r;
    pend_addr_nxt   = pend_addr_r;
    found_nxt       = found_r;
    slot_nxt        = slot_r;
    hit_to_nxt      = hit_to_r;
    hit_hid_nxt     = hit_hid_r;
    clr_cnt_nxt     = clr_cnt_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_slot_nxt    = out_slot_r;
    out_handler_nxt = out_handler_r;
    out_arg_nxt     = out_arg_r;
    out_state_nxt   = out_state_r;
    mem_we          = 1'b0;
    mem_waddr       = clr_cnt_r;
    mem_wdata       = '0;
    mem_re          = 1'b0;
    mem_raddr       = probe_idx_r;
    mod_start       = 1'b0;

    if (in_cmd == htt_pkg::CMD_DEFINE) begin
      mod_key = {EVENT_BITS'(in_event_id), STATE_BITS'(in_from_state)};
    end else begin
      mod_key = {EVENT_BITS'(in_event_id), present_r};
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (st_r)
      htt_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_cmd;
          from_nxt  = STATE_BITS'(in_from_state);
          to_nxt    = STATE_BITS'(in_to_state);
          ev_nxt    = EVENT_BITS'(in_event_id);
          hid_nxt   = in_handler_id;
          pay_nxt   = in_payload;
          mod_start = 1'b1;
          st_nxt    = htt_pkg::ST_HASH;
        end
      end
      htt_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
        if (clr_cnt_r == ADDR_W'(TABLE_DEPTH - 1)) begin
          st_nxt = htt_pkg::ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        end
      end
      htt_pkg::ST_HASH: begin
        if (mod_done) begin
          probe_idx_nxt = mod_rem;
          issued_nxt    = '0;
          pend_nxt      = 1'b0;
          found_nxt     = 1'b0;
          st_nxt        = htt_pkg::ST_PROBE;
        end
      end
      htt_pkg::ST_PROBE: begin
        // one read issued per cycle, its data checked the cycle after
        if (pend_r && match) begin
          found_nxt   = 1'b1;
          slot_nxt    = pend_addr_r;
          hit_to_nxt  = rd_ent.to_st;
          hit_hid_nxt = rd_ent.hid;
          pend_nxt    = 1'b0;
          st_nxt      = htt_pkg::ST_DONE;
        end else if (issued_r != eff_size) begin
          mem_re        = 1'b1;
          mem_raddr     = probe_idx_r;
          pend_nxt      = 1'b1;
          pend_addr_nxt = probe_idx_r;
          issued_nxt    = issued_r + SIZE_W'(1);
          probe_idx_nxt = probe_wrap ? '0 : probe_idx_r + ADDR_W'(1);
        end else begin
          found_nxt = 1'b0;
          pend_nxt  = 1'b0;
          st_nxt    = htt_pkg::ST_DONE;
        end
      end
      htt_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          st_nxt        = htt_pkg::ST_IDLE;
          if (cmd_r == htt_pkg::CMD_DEFINE) begin
            out_handler_nxt = '0;
            out_arg_nxt     = '0;
            out_state_nxt   = htt_pkg::STATE_PT_W'(present_r);
            if (found_r) begin
              out_status_nxt = htt_pkg::STS_DEFINED;
              out_slot_nxt   = htt_pkg::SLOT_W'(slot_r);
              mem_we         = 1'b1;
              mem_waddr      = slot_r;
              mem_wdata      = wr_ent;
            end else begin
              out_status_nxt = htt_pkg::STS_FULL;
              out_slot_nxt   = '0;
            end
          end else begin
            if (found_r) begin
              out_status_nxt  = htt_pkg::STS_TAKEN;
              out_slot_nxt    = htt_pkg::SLOT_W'(slot_r);
              out_handler_nxt = hit_hid_r;
              out_arg_nxt     = pay_r;
              present_nxt     = hit_to_r;
              out_state_nxt   = htt_pkg::STATE_PT_W'(hit_to_r);
            end else begin
              out_status_nxt  = htt_pkg::STS_NO_TRANS;
              out_slot_nxt    = '0;
              out_handler_nxt = '0;
              out_arg_nxt     = htt_pkg::ARG_W'(ev_r);
              out_state_nxt   = htt_pkg::STATE_PT_W'(present_r);
            end
          end
        end
      end
      default: begin
        st_nxt = htt_pkg::ST_IDLE;
      end
    endcase

    if (cfg_evt.load_state) begin
      present_nxt = STATE_BITS'(init_state);
    end
    // a new table size restarts the sweep from slot zero
    if (cfg_evt.clear) begin
      st_nxt      = htt_pkg::ST_CLEAR;
      clr_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= htt_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      issued_r    <= '0;
      present_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      issued_r    <= issued_nxt;
      present_r   <= present_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r         <= cmd_nxt;
    from_r        <= from_nxt;
    to_r          <= to_nxt;
    ev_r          <= ev_nxt;
    hid_r         <= hid_nxt;
    pay_r         <= pay_nxt;
    probe_idx_r   <= probe_idx_nxt;
    pend_addr_r   <= pend_addr_nxt;
    slot_r        <= slot_nxt;
    hit_to_r      <= hit_to_nxt;
    hit_hid_r     <= hit_hid_nxt;
    out_status_r  <= out_status_nxt;
    out_slot_r    <= out_slot_nxt;
    out_handler_r <= out_handler_nxt;
    out_arg_r     <= out_arg_nxt;
    out_state_r   <= out_state_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_slot            = out_slot_r;
  assign out_handler_to_call = out_handler_r;
  assign out_handler_arg     = out_arg_r;
  assign out_current_state   = out_state_r;

  `HTT_ASSERT_IMP(a_clear_blocks_input, st_r == htt_pkg::ST_CLEAR, !in_ready,
    "request accepted during table clear")
  `HTT_ASSERT_NXT(a_accept_starts_hash, in_valid && in_ready && !cfg_evt.clear,
    st_r == htt_pkg::ST_HASH, "accepted request did not start hashing")
  `HTT_ASSERT_IMP(a_probe_bound, st_r == htt_pkg::ST_PROBE, issued_r <= eff_size,
    "probe count ran past table size")
  `HTT_ASSERT_IMP(a_miss_fields,
    out_valid_r && (out_status_r == htt_pkg::STS_NO_TRANS || out_status_r == htt_pkg::STS_FULL),
    out_slot_r == '0 && out_handler_r == '0, "miss or full result carries a slot or handler")

endmodule

// ----- test/htt_result_checker.sv -----
`timescale 1ns / 1ps
// result checker for hashed_transition_table_fsm: follows the request, result and config
// channels, predicts every result from a private copy of the transition table and compares
// depends on htt_pkg
module htt_result_checker #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            in_cmd,
  input  logic [htt_pkg::STATE_PT_W-1:0]  in_from_state,
  input  logic [htt_pkg::STATE_PT_W-1:0]  in_to_state,
  input  logic [htt_pkg::EVENT_PT_W-1:0]  in_event_id,
  input  logic [htt_pkg::HID_W-1:0]       in_handler_id,
  input  logic [htt_pkg::ARG_W-1:0]       in_payload,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [htt_pkg::STS_W-1:0]       out_status,
  input  logic [htt_pkg::SLOT_W-1:0]      out_slot,
  input  logic [htt_pkg::HID_W-1:0]       out_handler_to_call,
  input  logic [htt_pkg::ARG_W-1:0]       out_handler_arg,
  input  logic [htt_pkg::STATE_PT_W-1:0]  out_current_state,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [htt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [htt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                              fail_cnt,
  output int                              pending_cnt,
  output int                              checked_cnt
);

  localparam int EXP_DEPTH = 8;

  typedef struct {
    htt_pkg::status_t                 status;
    logic [htt_pkg::SLOT_W-1:0]       slot;
    logic [htt_pkg::HID_W-1:0]        handler;
    logic [htt_pkg::ARG_W-1:0]        arg;
    logic [htt_pkg::STATE_PT_W-1:0]   state;
  } fsm_result_t;

  logic                           slot_used    [TABLE_DEPTH];
  logic [htt_pkg::STATE_PT_W-1:0] slot_from    [TABLE_DEPTH];
  logic [htt_pkg::STATE_PT_W-1:0] slot_to      [TABLE_DEPTH];
  logic [htt_pkg::EVENT_PT_W-1:0] slot_event   [TABLE_DEPTH];
  logic [htt_pkg::HID_W-1:0]      slot_handler [TABLE_DEPTH];
  logic [htt_pkg::TSIZE_W-1:0]    size_reg;
  logic [htt_pkg::STATE_PT_W-1:0] fsm_state;
  // expected results in request order, as a small ring
  fsm_result_t                    expected_mem [EXP_DEPTH];
  int                             exp_head;
  int                             exp_tail;
  int                             exp_count;

  function automatic void clear_slots();
    foreach (slot_used[i]) slot_used[i] = 1'b0;
  endfunction

  // one request through the table: probe, update, and build its result
  function automatic fsm_result_t step_fsm(logic cmd,
                                           logic [htt_pkg::STATE_PT_W-1:0] from_st,
                                           logic [htt_pkg::STATE_PT_W-1:0] to_st,
                                           logic [htt_pkg::EVENT_PT_W-1:0] ev,
                                           logic [htt_pkg::HID_W-1:0] hid,
                                           logic [htt_pkg::ARG_W-1:0] pay);
    int          size;
    int          base;
    int          idx;
    bit          hit;
    fsm_result_t r;
    size = (size_reg == 0) ? 1 : ((size_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(size_reg));
    hit = 1'b0;
    idx = 0;
    r.slot = '0;
    r.handler = '0;
    r.arg = '0;
    if (cmd == htt_pkg::CMD_DEFINE) begin
      base = (int'(from_st) + (int'(ev) << htt_pkg::STATE_PT_W)) % size;
      for (int i = 0; i < size && !hit; i++) begin
        idx = (base + i) % size;
        if (!slot_used[idx]) hit = 1'b1;
      end
      if (hit) begin
        slot_used[idx] = 1'b1;
        slot_from[idx] = from_st;
        slot_to[idx] = to_st;
        slot_event[idx] = ev;
        slot_handler[idx] = hid;
        r.status = htt_pkg::STS_DEFINED;
        r.slot = htt_pkg::SLOT_W'(idx);
      end else begin
        r.status = htt_pkg::STS_FULL;
      end
    end else begin
      base = (int'(fsm_state) + (int'(ev) << htt_pkg::STATE_PT_W)) % size;
      for (int i = 0; i < size && !hit; i++) begin
        idx = (base + i) % size;
        if (slot_used[idx] && slot_from[idx] == fsm_state && slot_event[idx] == ev) hit = 1'b1;
      end
      if (hit) begin
        r.status = htt_pkg::STS_TAKEN;
        r.slot = htt_pkg::SLOT_W'(idx);
        r.handler = slot_handler[idx];
        r.arg = pay;
        fsm_state = slot_to[idx];
      end else begin
        r.status = htt_pkg::STS_NO_TRANS;
        r.arg = htt_pkg::ARG_W'(ev);
      end
    end
    r.state = fsm_state;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin : watch
    fsm_result_t want;
    fsm_result_t pred;
    if (!rst_n) begin
      clear_slots();
      size_reg = htt_pkg::TSIZE_W'(256);
      fsm_state = '0;
      exp_head = 0;
      exp_tail = 0;
      exp_count = 0;
      fail_cnt = 0;
      checked_cnt = 0;
    end else begin
      // results first, so a request taken on the same edge is never matched to it
      if (out_valid && out_ready) begin
        if (exp_count == 0) begin
          $error("result with no request outstanding: status 0x%0h slot 0x%0h",
                 out_status, out_slot);
          fail_cnt++;
        end else begin
          want = expected_mem[exp_head];
          exp_head = (exp_head + 1) % EXP_DEPTH;
          exp_count--;
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("slot", 32'(want.slot), 32'(out_slot));
          check_field("handler_to_call", 32'(want.handler), 32'(out_handler_to_call));
          check_field("handler_arg", want.arg, out_handler_arg);
          check_field("current_state", 32'(want.state), 32'(out_current_state));
          checked_cnt++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == htt_pkg::CFG_TABLE_SIZE) begin
          size_reg = cfg_wdata[htt_pkg::TSIZE_W-1:0];
          clear_slots();
        end else if (cfg_index == htt_pkg::CFG_INITIAL_STATE) begin
          fsm_state = cfg_wdata[htt_pkg::STATE_PT_W-1:0];
        end
      end
      if (in_valid && in_ready) begin
        pred = step_fsm(in_cmd, in_from_state, in_to_state, in_event_id,
                        in_handler_id, in_payload);
        if (exp_count == EXP_DEPTH) begin
          $error("more requests outstanding than the checker can hold");
          fail_cnt++;
        end else begin
          expected_mem[exp_tail] = pred;
          exp_tail = (exp_tail + 1) % EXP_DEPTH;
          exp_count++;
        end
      end
    end
    pending_cnt = exp_count;
  end

endmodule

// ----- test/hashed_transition_table_fsm_tb.sv -----
`timescale 1ns / 1ps
// testbench top for hashed_transition_table_fsm: drives requests, config writes and result
// back-pressure; htt_result_checker does all prediction and comparison
// depends on htt_pkg, hashed_transition_table_fsm and htt_result_checker
module hashed_transition_table_fsm_tb;

  localparam int NUM_PHASES     = 20;
  localparam int PHASE_REQS     = 55;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 300;
  localparam logic [htt_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           in_cmd = htt_pkg::CMD_DEFINE;
  logic [htt_pkg::STATE_PT_W-1:0] in_from_state = '0;
  logic [htt_pkg::STATE_PT_W-1:0] in_to_state = '0;
  logic [htt_pkg::EVENT_PT_W-1:0] in_event_id = '0;
  logic [htt_pkg::HID_W-1:0]      in_handler_id = '0;
  logic [htt_pkg::ARG_W-1:0]      in_payload = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b1;
  logic [htt_pkg::STS_W-1:0]      out_status;
  logic [htt_pkg::SLOT_W-1:0]     out_slot;
  logic [htt_pkg::HID_W-1:0]      out_handler_to_call;
  logic [htt_pkg::ARG_W-1:0]      out_handler_arg;
  logic [htt_pkg::STATE_PT_W-1:0] out_current_state;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [htt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [htt_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  int fail_cnt;
  int pending_cnt;
  int checked_cnt;
  int reqs_sent = 0;
  int settings_used = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  bit hold_off_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hashed_transition_table_fsm u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cmd              (in_cmd),
    .in_from_state       (in_from_state),
    .in_to_state         (in_to_state),
    .in_event_id         (in_event_id),
    .in_handler_id       (in_handler_id),
    .in_payload          (in_payload),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_slot            (out_slot),
    .out_handler_to_call (out_handler_to_call),
    .out_handler_arg     (out_handler_arg),
    .out_current_state   (out_current_state),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  htt_result_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cmd              (in_cmd),
    .in_from_state       (in_from_state),
    .in_to_state         (in_to_state),
    .in_event_id         (in_event_id),
    .in_handler_id       (in_handler_id),
    .in_payload          (in_payload),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_slot            (out_slot),
    .out_handler_to_call (out_handler_to_call),
    .out_handler_arg     (out_handler_arg),
    .out_current_state   (out_current_state),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .fail_cnt            (fail_cnt),
    .pending_cnt         (pending_cnt),
    .checked_cnt         (checked_cnt)
  );

  // called at a falling edge; returns on a falling edge after acceptance and any random gap
  task automatic send_req(logic cmd, logic [htt_pkg::STATE_PT_W-1:0] from_st,
                          logic [htt_pkg::STATE_PT_W-1:0] to_st,
                          logic [htt_pkg::EVENT_PT_W-1:0] ev,
                          logic [htt_pkg::HID_W-1:0] hid, logic [htt_pkg::ARG_W-1:0] pay);
    in_valid = 1'b1;
    in_cmd = cmd;
    in_from_state = from_st;
    in_to_state = to_st;
    in_event_id = ev;
    in_handler_id = hid;
    in_payload = pay;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    reqs_sent++;
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_cnt != 0) @(negedge clk);
  endtask

  // waits for the sequencer to be idle (clearing pass done) before writing
  task automatic write_reg(logic [htt_pkg::CFG_IDX_W-1:0] idx,
                           logic [htt_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx == htt_pkg::CFG_TABLE_SIZE) settings_used++;
  endtask

  // result side back-pressure
  initial begin : result_sink
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_off_req = 1'b0;
        out_ready = 1'b1;
      end else if (stalls_on && $urandom_range(0, 4) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_ready = 1'b1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  initial begin : watchdog
    #15_000_000;
    $display("hashed_transition_table_fsm_tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    logic [htt_pkg::STATE_PT_W-1:0] st_pool [4];
    logic [htt_pkg::EVENT_PT_W-1:0] ev_pool [3];
    logic [htt_pkg::CFG_DATA_W-1:0] tsize;
    int                             pick;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // full-size table after reset, present state 0
    send_req(htt_pkg::CMD_EVENT, 8'h00, 8'h00, 8'hFF, 8'h00, 32'hFFFF_FFFF);  // empty table
    send_req(htt_pkg::CMD_DEFINE, 8'h00, 8'hFF, 8'h00, 8'hFF, 32'h0);
    send_req(htt_pkg::CMD_DEFINE, 8'h00, 8'h05, 8'h00, 8'h01, 32'h0);  // same key, next slot
    send_req(htt_pkg::CMD_EVENT, 8'h00, 8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF);  // earliest wins
    send_req(htt_pkg::CMD_DEFINE, 8'hFF, 8'h00, 8'hFF, 8'h80, 32'h0);  // hashes to last slot
    send_req(htt_pkg::CMD_DEFINE, 8'hFF, 8'h00, 8'hFF, 8'h81, 32'h0);  // probe wraps past 0, 1
    send_req(htt_pkg::CMD_EVENT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hA5A5_5A5A);
    send_req(htt_pkg::CMD_EVENT, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0000_0000);
    drain_results();

    // size 0 acts as a single slot; top bit of initial state is dropped
    write_reg(htt_pkg::CFG_TABLE_SIZE, 9'd0);
    write_reg(htt_pkg::CFG_INITIAL_STATE, 9'h1AB);
    send_req(htt_pkg::CMD_DEFINE, 8'hAB, 8'h55, 8'h01, 8'h07, 32'h0);
    send_req(htt_pkg::CMD_DEFINE, 8'h12, 8'h34, 8'h34, 8'h09, 32'h0);  // table full
    send_req(htt_pkg::CMD_EVENT, 8'h00, 8'h00, 8'h01, 8'h00, 32'h1234_5678);
    send_req(htt_pkg::CMD_EVENT, 8'h00, 8'h00, 8'h01, 8'h00, 32'h1234_5678);  // miss, new state
    drain_results();

    write_reg(htt_pkg::CFG_TABLE_SIZE, 9'd3);
    write_reg(htt_pkg::CFG_INITIAL_STATE, 9'h000);
    send_req(htt_pkg::CMD_DEFINE, 8'h00, 8'h01, 8'h02, 8'h11, 32'h0);
    send_req(htt_pkg::CMD_DEFINE, 8'h01, 8'h00, 8'h02, 8'h22, 32'h0);
    send_req(htt_pkg::CMD_DEFINE, 8'h00, 8'h02, 8'h02, 8'h33, 32'h0);
    send_req(htt_pkg::CMD_DEFINE, 8'h07, 8'h07, 8'h07, 8'h44, 32'h0);  // table full
    send_req(htt_pkg::CMD_EVENT, 8'h00, 8'h00, 8'h02, 8'h00, 32'hDEAD_BEEF);
    send_req(htt_pkg::CMD_EVENT, 8'h00, 8'h00, 8'h02, 8'h00, 32'hCAFE_F00D);
    send_req(htt_pkg::CMD_EVENT, 8'h00, 8'h00, 8'h7F, 8'h00, 32'h0);  // miss over full table
    drain_results();

    // unmapped index is ignored; size above depth acts as full depth
    write_reg(CFG_SPARE_IDX, 9'h1FF);
    write_reg(htt_pkg::CFG_TABLE_SIZE, 9'h1FF);
    send_req(htt_pkg::CMD_DEFINE, 8'h00, 8'h80, 8'hFF, 8'h01, 32'h0);
    send_req(htt_pkg::CMD_EVENT, 8'h00, 8'h00, 8'hFF, 8'h00, 32'h8000_0001);
    drain_results();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0: begin
          tsize = 9'd0;
        end
        1: begin
          tsize = 9'd256;
        end
        2: begin
          tsize = 9'($urandom_range(257, 511));
        end
        3, 4: begin
          tsize = 9'($urandom_range(17, 64));
        end
        default: begin
          tsize = 9'($urandom_range(1, 16));
        end
      endcase
      foreach (st_pool[i]) st_pool[i] = 8'($urandom);
      foreach (ev_pool[i]) ev_pool[i] = 8'($urandom);
      write_reg(htt_pkg::CFG_TABLE_SIZE, tsize);
      write_reg(htt_pkg::CFG_INITIAL_STATE,
                {1'($urandom_range(0, 1)), st_pool[$urandom_range(0, 3)]});
      if (ph >= NUM_PHASES - 2) begin
        gaps_on = 1'b0;
        stalls_on = 1'b0;
      end
      // receiver stops for a long stretch while requests keep coming
      if (ph == 1) hold_off_req = 1'b1;
      for (int n = 0; n < PHASE_REQS; n++) begin
        pick = $urandom_range(0, 19);
        if (pick < 5)
          send_req(htt_pkg::CMD_DEFINE, st_pool[$urandom_range(0, 3)],
                   st_pool[$urandom_range(0, 3)], ev_pool[$urandom_range(0, 2)],
                   8'($urandom), $urandom);
        else if (pick < 17)
          send_req(htt_pkg::CMD_EVENT, 8'($urandom), 8'($urandom),
                   ev_pool[$urandom_range(0, 2)], 8'($urandom), $urandom);
        else
          send_req(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), $urandom);
      end
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d requests over %0d table size settings, %0d results compared",
             reqs_sent, settings_used, checked_cnt);
    $display("included full tables, probe wrap-around, long result stall and idle-free tail");
    if (fail_cnt == 0 && pending_cnt == 0)
      $display("hashed_transition_table_fsm_tb: done, clean");
    else
      $display("hashed_transition_table_fsm_tb: done, errors");
    $finish;
  end

endmodule
